FILE: sv/geometry_predicate_unit_assert.svh
// assertion macros for the geometry predicate unit
`ifndef GEOMETRY_PREDICATE_UNIT_ASSERT_SVH
`define GEOMETRY_PREDICATE_UNIT_ASSERT_SVH

`ifndef SYNTH
`define GPU_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gpu assertion failed");
`define GPU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gpu assertion failed");
`else
`define GPU_ASSERT_SAME(lbl, ante, cons)
`define GPU_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: sv/gpu_pkg.sv
`default_nettype none

package gpu_pkg;

	localparam logic [2:0] FN_ORIENT     = 3'd0;
	localparam logic [2:0] FN_ON_SEG     = 3'd1;
	localparam logic [2:0] FN_SAME_SIDE  = 3'd2;
	localparam logic [2:0] FN_SEG_MEET   = 3'd3;
	localparam logic [2:0] FN_TRI_OPEN   = 3'd4;
	localparam logic [2:0] FN_TRI_CLOSED = 3'd5;
	localparam logic [2:0] FN_SEG_LINE   = 3'd6;

	localparam logic [1:0] ORIENT_ZERO = 2'd0;
	localparam logic [1:0] ORIENT_CCW  = 2'd1;
	localparam logic [1:0] ORIENT_CW   = 2'd2;

	localparam int PT_A = 0;
	localparam int PT_B = 1;
	localparam int PT_C = 2;
	localparam int PT_D = 3;

	typedef logic signed [33:0] cross_t;

	typedef struct packed {
		logic pos;
		logic neg;
	} sgn_t;

	typedef struct packed {
		sgn_t abc;
		sgn_t abd;
		sgn_t cda;
		sgn_t cdb;
		sgn_t bcd;
		sgn_t cad;
	} sgn_set_t;

endpackage

`default_nettype wire

FILE: sv/gpu_if.sv
`default_nettype none

interface gpu_req_if #(parameter int COORD_BITS = 16);
	logic                         valid;
	logic                         ready;
	logic [2:0]                   func;
	logic signed [COORD_BITS-1:0] point_a_x;
	logic signed [COORD_BITS-1:0] point_a_y;
	logic signed [COORD_BITS-1:0] point_b_x;
	logic signed [COORD_BITS-1:0] point_b_y;
	logic signed [COORD_BITS-1:0] point_c_x;
	logic signed [COORD_BITS-1:0] point_c_y;
	logic signed [COORD_BITS-1:0] point_d_x;
	logic signed [COORD_BITS-1:0] point_d_y;

	modport source (
		output valid, func, point_a_x, point_a_y, point_b_x, point_b_y,
		       point_c_x, point_c_y, point_d_x, point_d_y,
		input  ready
	);
	modport sink (
		input  valid, func, point_a_x, point_a_y, point_b_x, point_b_y,
		       point_c_x, point_c_y, point_d_x, point_d_y,
		output ready
	);
endinterface

interface gpu_rsp_if;
	logic            valid;
	logic            ready;
	logic            hit;
	logic [1:0]      orient_code;
	gpu_pkg::cross_t cross_value;

	modport source (output valid, hit, orient_code, cross_value, input ready);
	modport sink (input valid, hit, orient_code, cross_value, output ready);
endinterface

`default_nettype wire

FILE: sv/gpu_cross.sv
`default_nettype none

module gpu_cross #(
	parameter int COORD_BITS = 16
) (
	input  wire logic                           clk,
	input  wire logic                           en,
	input  wire logic signed [COORD_BITS-1:0]   p_x,
	input  wire logic signed [COORD_BITS-1:0]   p_y,
	input  wire logic signed [COORD_BITS-1:0]   q_x,
	input  wire logic signed [COORD_BITS-1:0]   q_y,
	input  wire logic signed [COORD_BITS-1:0]   r_x,
	input  wire logic signed [COORD_BITS-1:0]   r_y,
	output logic signed [2*COORD_BITS+2:0]      cross_val,
	output gpu_pkg::sgn_t                       sign
);

	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * COORD_BITS + 2;
	localparam int CW = PW + 1;

	logic signed [DW-1:0] ux, uy, vx, vy;
	logic signed [PW-1:0] m_uv, m_vu;
	logic signed [PW-1:0] m_uv_s2, m_vu_s2;

	assign ux = DW'(q_x) - DW'(p_x);
	assign uy = DW'(q_y) - DW'(p_y);
	assign vx = DW'(r_x) - DW'(p_x);
	assign vy = DW'(r_y) - DW'(p_y);

	assign m_uv = PW'(ux) * PW'(vy);
	assign m_vu = PW'(uy) * PW'(vx);

	always_ff @(posedge clk) begin
		if (en) begin
			m_uv_s2 <= m_uv;
			m_vu_s2 <= m_vu;
		end
	end

	assign cross_val = CW'(m_uv_s2) - CW'(m_vu_s2);
	assign sign.neg  = cross_val[CW-1];
	assign sign.pos  = !cross_val[CW-1] && (cross_val != '0);

endmodule

`default_nettype wire

FILE: sv/gpu_decide.sv
`default_nettype none

module gpu_decide #(
	parameter int COORD_BITS = 16
) (
	input  wire logic [2:0]                   func,
	input  wire logic signed [COORD_BITS-1:0] x [4],
	input  wire logic signed [COORD_BITS-1:0] y [4],
	input  wire gpu_pkg::sgn_set_t            signs,
	output logic                              hit
);

	function automatic logic between(
		input logic signed [COORD_BITS-1:0] p,
		input logic signed [COORD_BITS-1:0] q,
		input logic signed [COORD_BITS-1:0] r
	);
		return ((p <= r) && (r <= q)) || ((q <= r) && (r <= p));
	endfunction

	function automatic logic overlap(
		input logic signed [COORD_BITS-1:0] a,
		input logic signed [COORD_BITS-1:0] b,
		input logic signed [COORD_BITS-1:0] c,
		input logic signed [COORD_BITS-1:0] d
	);
		logic signed [COORD_BITS-1:0] hi_ab, lo_ab, hi_cd, lo_cd;
		hi_ab = (a > b) ? a : b;
		lo_ab = (a < b) ? a : b;
		hi_cd = (c > d) ? c : d;
		lo_cd = (c < d) ? c : d;
		return (hi_ab >= lo_cd) && (hi_cd >= lo_ab);
	endfunction

	function automatic logic straddle(input gpu_pkg::sgn_t s, input gpu_pkg::sgn_t t);
		return !((s.pos && t.pos) || (s.neg && t.neg));
	endfunction

	function automatic logic is_zero(input gpu_pkg::sgn_t s);
		return !s.pos && !s.neg;
	endfunction

	localparam int A = gpu_pkg::PT_A;
	localparam int B = gpu_pkg::PT_B;
	localparam int C = gpu_pkg::PT_C;
	localparam int D = gpu_pkg::PT_D;

	logic box_abc, box_abd, box_bcd, box_cad, box_meet;
	logic on_ab_c, on_ab_d, on_bc_d, on_ca_d, tri_open, line_cut;

	assign box_abc  = between(x[A], x[B], x[C]) && between(y[A], y[B], y[C]);
	assign box_abd  = between(x[A], x[B], x[D]) && between(y[A], y[B], y[D]);
	assign box_bcd  = between(x[B], x[C], x[D]) && between(y[B], y[C], y[D]);
	assign box_cad  = between(x[C], x[A], x[D]) && between(y[C], y[A], y[D]);
	assign box_meet = overlap(x[A], x[B], x[C], x[D]) && overlap(y[A], y[B], y[C], y[D]);

	assign on_ab_c  = is_zero(signs.abc) && box_abc;
	assign on_ab_d  = is_zero(signs.abd) && box_abd;
	assign on_bc_d  = is_zero(signs.bcd) && box_bcd;
	assign on_ca_d  = is_zero(signs.cad) && box_cad;
	assign tri_open = !is_zero(signs.abd) && (signs.abd == signs.bcd)
	                  && (signs.bcd == signs.cad);
	assign line_cut = straddle(signs.abc, signs.abd);

	always_comb begin
		unique case (func)
			gpu_pkg::FN_ON_SEG:     hit = on_ab_c;
			gpu_pkg::FN_SAME_SIDE:  hit = (signs.abc == signs.abd);
			gpu_pkg::FN_SEG_MEET:   hit = line_cut && straddle(signs.cda, signs.cdb)
			                              && box_meet;
			gpu_pkg::FN_TRI_OPEN:   hit = tri_open;
			gpu_pkg::FN_TRI_CLOSED: hit = on_ab_d || on_bc_d || on_ca_d || tri_open;
			gpu_pkg::FN_SEG_LINE:   hit = line_cut;
			default:                hit = 1'b0;
		endcase
	end

endmodule

`default_nettype wire

FILE: sv/geometry_predicate_unit.sv
// geometry_predicate_unit: exact integer 2D predicates on four points A, B, C, D.
// req carries func and the eight coordinates; rsp returns hit, orient_code
// (sign of (B-A)x(C-A)) and cross_value, the low 34 bits of that cross product.
// Both channels use valid/ready; a request moves when both are high.
// A request passes an input register, a register after the cross-product
// multipliers and the result register. Throughput is one request per cycle
// while rsp.ready is high or the result register is empty; six cross-product
// lanes with two multipliers each work side by side; every request passes once.
// The three stages advance together: req.ready is high whenever the result
// register is empty or rsp.ready is high, so a stalled receiver holds the
// result and the items behind it; bubbles in the earlier stages are held too.
// Reset clears the stage valid bits; no request is in flight after reset and
// the block is ready at once. There are no configuration registers.
`default_nettype none

module geometry_predicate_unit #(
	parameter int COORD_BITS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	gpu_req_if.sink   req,
	gpu_rsp_if.source rsp
);

`include "geometry_predicate_unit_assert.svh"

	localparam int CW = 2 * COORD_BITS + 3;

	logic                         adv;
	logic                         valid_s1, valid_s2, valid_s3;
	logic [2:0]                   func_s1, func_s2;
	logic signed [COORD_BITS-1:0] x_s1 [4];
	logic signed [COORD_BITS-1:0] y_s1 [4];
	logic signed [COORD_BITS-1:0] x_s2 [4];
	logic signed [COORD_BITS-1:0] y_s2 [4];
	logic signed [CW-1:0]         cr_abc, cr_abd, cr_cda, cr_cdb, cr_bcd, cr_cad;
	gpu_pkg::sgn_set_t            signs;
	logic                         hit_d;
	logic [1:0]                   orient_d;
	logic                         hit_s3;
	logic [1:0]                   orient_s3;
	gpu_pkg::cross_t              cross_s3;

	assign adv       = !valid_s3 || rsp.ready;
	assign req.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= req.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			func_s1           <= req.func;
			x_s1[gpu_pkg::PT_A] <= req.point_a_x;
			y_s1[gpu_pkg::PT_A] <= req.point_a_y;
			x_s1[gpu_pkg::PT_B] <= req.point_b_x;
			y_s1[gpu_pkg::PT_B] <= req.point_b_y;
			x_s1[gpu_pkg::PT_C] <= req.point_c_x;
			y_s1[gpu_pkg::PT_C] <= req.point_c_y;
			x_s1[gpu_pkg::PT_D] <= req.point_d_x;
			y_s1[gpu_pkg::PT_D] <= req.point_d_y;
			func_s2           <= func_s1;
			x_s2              <= x_s1;
			y_s2              <= y_s1;
			hit_s3            <= hit_d;
			orient_s3         <= orient_d;
			cross_s3          <= gpu_pkg::cross_t'(cr_abc);
		end
	end

	// cross-product lanes: (q-p)x(r-p)
	gpu_cross #(.COORD_BITS(COORD_BITS)) u_abc (
		.clk(clk), .en(adv),
		.p_x(x_s1[gpu_pkg::PT_A]), .p_y(y_s1[gpu_pkg::PT_A]),
		.q_x(x_s1[gpu_pkg::PT_B]), .q_y(y_s1[gpu_pkg::PT_B]),
		.r_x(x_s1[gpu_pkg::PT_C]), .r_y(y_s1[gpu_pkg::PT_C]),
		.cross_val(cr_abc), .sign(signs.abc)
	);

	gpu_cross #(.COORD_BITS(COORD_BITS)) u_abd (
		.clk(clk), .en(adv),
		.p_x(x_s1[gpu_pkg::PT_A]), .p_y(y_s1[gpu_pkg::PT_A]),
		.q_x(x_s1[gpu_pkg::PT_B]), .q_y(y_s1[gpu_pkg::PT_B]),
		.r_x(x_s1[gpu_pkg::PT_D]), .r_y(y_s1[gpu_pkg::PT_D]),
		.cross_val(cr_abd), .sign(signs.abd)
	);

	gpu_cross #(.COORD_BITS(COORD_BITS)) u_cda (
		.clk(clk), .en(adv),
		.p_x(x_s1[gpu_pkg::PT_C]), .p_y(y_s1[gpu_pkg::PT_C]),
		.q_x(x_s1[gpu_pkg::PT_D]), .q_y(y_s1[gpu_pkg::PT_D]),
		.r_x(x_s1[gpu_pkg::PT_A]), .r_y(y_s1[gpu_pkg::PT_A]),
		.cross_val(cr_cda), .sign(signs.cda)
	);

	gpu_cross #(.COORD_BITS(COORD_BITS)) u_cdb (
		.clk(clk), .en(adv),
		.p_x(x_s1[gpu_pkg::PT_C]), .p_y(y_s1[gpu_pkg::PT_C]),
		.q_x(x_s1[gpu_pkg::PT_D]), .q_y(y_s1[gpu_pkg::PT_D]),
		.r_x(x_s1[gpu_pkg::PT_B]), .r_y(y_s1[gpu_pkg::PT_B]),
		.cross_val(cr_cdb), .sign(signs.cdb)
	);

	gpu_cross #(.COORD_BITS(COORD_BITS)) u_bcd (
		.clk(clk), .en(adv),
		.p_x(x_s1[gpu_pkg::PT_B]), .p_y(y_s1[gpu_pkg::PT_B]),
		.q_x(x_s1[gpu_pkg::PT_C]), .q_y(y_s1[gpu_pkg::PT_C]),
		.r_x(x_s1[gpu_pkg::PT_D]), .r_y(y_s1[gpu_pkg::PT_D]),
		.cross_val(cr_bcd), .sign(signs.bcd)
	);

	gpu_cross #(.COORD_BITS(COORD_BITS)) u_cad (
		.clk(clk), .en(adv),
		.p_x(x_s1[gpu_pkg::PT_C]), .p_y(y_s1[gpu_pkg::PT_C]),
		.q_x(x_s1[gpu_pkg::PT_A]), .q_y(y_s1[gpu_pkg::PT_A]),
		.r_x(x_s1[gpu_pkg::PT_D]), .r_y(y_s1[gpu_pkg::PT_D]),
		.cross_val(cr_cad), .sign(signs.cad)
	);

	gpu_decide #(.COORD_BITS(COORD_BITS)) u_decide (
		.func(func_s2), .x(x_s2), .y(y_s2), .signs(signs), .hit(hit_d)
	);

	always_comb begin
		priority if (signs.abc.pos) begin
			orient_d = gpu_pkg::ORIENT_CCW;
		end else if (signs.abc.neg) begin
			orient_d = gpu_pkg::ORIENT_CW;
		end else begin
			orient_d = gpu_pkg::ORIENT_ZERO;
		end
	end

	assign rsp.valid       = valid_s3;
	assign rsp.hit         = hit_s3;
	assign rsp.orient_code = orient_s3;
	assign rsp.cross_value = cross_s3;

	// unused lane outputs beyond their signs
	logic unused_cross;
	assign unused_cross = ^{cr_abd, cr_cda, cr_cdb, cr_bcd, cr_cad};

	`GPU_ASSERT_NEXT(a_orient_no_hit, adv && valid_s2 && (func_s2 == gpu_pkg::FN_ORIENT), !rsp.hit)
	`GPU_ASSERT_SAME(a_orient_legal, rsp.valid, rsp.orient_code != 2'b11)
	`GPU_ASSERT_SAME(a_zero_cross, rsp.valid && (rsp.orient_code == gpu_pkg::ORIENT_ZERO), rsp.cross_value == '0)
	`GPU_ASSERT_NEXT(a_stage_move, adv && valid_s1, valid_s2)
	`GPU_ASSERT_NEXT(a_stall_keep, valid_s3 && !rsp.ready, valid_s3)

endmodule

`default_nettype wire
